[src/sha256_hash_engine_macros.svh]
// assertion macros for the sha-256 hash engine
`ifndef SHA256_HASH_ENGINE_MACROS_SVH
`define SHA256_HASH_ENGINE_MACROS_SVH

`ifndef SYNTHESIS

// property that holds on every rising clock edge outside reset
`define SHA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sha256 engine assertion failed");

// antecedent this cycle, consequent on the next edge
`define SHA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sha256 engine assertion failed");

`else

`define SHA_ASSERT(lbl, clk, rst_n, prop)
`define SHA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[src/sha_pkg.sv]
// constants and helper functions of the sha-256 hash engine
package sha_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned NUM_HASH = 8;
    localparam int unsigned BLOCK_W  = 512;
    localparam int unsigned ROUNDS   = 64;
    localparam logic [7:0]  PAD_MARK = 8'h80;
    localparam logic [5:0]  LEN_POS  = 6'd56;
    localparam logic [5:0]  FILL_TOP = 6'd63;

    typedef logic [WORD_W-1:0] word_t;

    // initial hash words
    localparam word_t IV [NUM_HASH] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // round constant table
    function automatic word_t round_k(input logic [5:0] idx);
        word_t k;
        case (idx)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = '0;
        endcase
        return k;
    endfunction

    function automatic word_t rotr(input word_t x, input int unsigned n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic word_t big_sig0(input word_t x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big_sig1(input word_t x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t small_sig0(input word_t x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t small_sig1(input word_t x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

[src/sha256_hash_engine.sv]
// sha-256 hash engine: byte absorber, padding sequencer and iterative round unit
//
// Input channel s_*: each transfer carries up to four message bytes in
// s_tdata[31:0] (first byte in bits 31:24), the byte count in s_tdata[34:32]
// (values above four count as four) and s_tlast, which ends the message.
// Output channel m_*: after a transfer with s_tlast the engine pads the
// message, finishes it and presents the eight digest words in order,
// word 0 first; m_tlast marks word 7.
// Flow: s_tready is high only while the engine is idle. The bytes of an
// accepted transfer go one byte per cycle into the 512-bit block shift
// register, except while a compression runs. Every 64th byte starts a
// compression: 64 rounds through the single round unit, one round per
// cycle, then an update step that adds the working words into the chaining
// value. After the final transfer the engine appends the pad byte, zero
// bytes and the length, running one or two compressions, after which
// the digest is offered. Each digest word waits for m_tready; the engine
// holds it unchanged and does nothing else while the receiver stalls.
// After word 7 is taken the engine returns to the initial hash value.
// Reset (rst_n low, asynchronous) returns to idle with the initial hash
// value, an empty block and a zero length.
`include "sha256_hash_engine_macros.svh"

module sha256_hash_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // data_word[31:0], byte_count[34:32], zeros
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // digest_word[31:0], word_index[34:32], zeros
    output logic        m_tlast
);

    import sha_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ABSORB,
        S_PAD,
        S_LEN,
        S_ROUND,
        S_UPDATE,
        S_OUT
    } state_t;

    state_t             state_reg, state_next;
    state_t             resume_reg, resume_next;
    logic [5:0]         fill_reg, fill_next;
    logic [63:0]        bit_len_reg, bit_len_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic               last_reg, last_next;
    logic               mark_reg, mark_next;
    logic [3:0]         len_cnt_reg, len_cnt_next;
    logic [5:0]         round_reg, round_next;
    logic [2:0]         idx_reg, idx_next;
    word_t              chain_reg [NUM_HASH];
    word_t              chain_next [NUM_HASH];
    // payload, no reset
    logic [BLOCK_W-1:0] blk_reg, blk_next;
    word_t              data_reg, data_next;
    word_t              work_reg [NUM_HASH];
    word_t              work_next [NUM_HASH];

    logic               push_en;
    logic [7:0]         push_byte;
    state_t             after_push;
    logic [2:0]         in_cnt;
    word_t              t1, t2, sched_new;

    // saturated byte count of the incoming transfer
    assign in_cnt = (s_tdata[34:32] > 3'd4) ? 3'd4 : s_tdata[34:32];

    // round unit and schedule extension
    always_comb
    begin
        t1 = work_reg[7] + big_sig1(work_reg[4])
           + ((work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]))
           + round_k(round_reg) + blk_reg[511:480];
        t2 = big_sig0(work_reg[0])
           + ((work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
              ^ (work_reg[1] & work_reg[2]));
        sched_new = blk_reg[511:480] + small_sig0(blk_reg[479:448])
                  + blk_reg[223:192] + small_sig1(blk_reg[63:32]);
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        resume_next  = resume_reg;
        fill_next    = fill_reg;
        bit_len_next = bit_len_reg;
        cnt_next     = cnt_reg;
        last_next    = last_reg;
        mark_next    = mark_reg;
        len_cnt_next = len_cnt_reg;
        round_next   = round_reg;
        idx_next     = idx_reg;
        chain_next   = chain_reg;
        blk_next     = blk_reg;
        data_next    = data_reg;
        work_next    = work_reg;
        push_en      = 1'b0;
        push_byte    = '0;
        after_push   = state_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    data_next    = s_tdata[31:0];
                    cnt_next     = in_cnt;
                    last_next    = s_tlast;
                    bit_len_next = bit_len_reg + {58'd0, in_cnt, 3'd0};
                    if (in_cnt != 3'd0)
                        state_next = S_ABSORB;
                    else if (s_tlast)
                        state_next = S_PAD;
                end
            end
            S_ABSORB:
            begin
                push_en   = 1'b1;
                push_byte = data_reg[31:24];
                data_next = {data_reg[23:0], 8'd0};
                cnt_next  = cnt_reg - 3'd1;
                if (cnt_reg == 3'd1)
                    after_push = last_reg ? S_PAD : S_IDLE;
            end
            S_PAD:
            begin
                if (!mark_reg)
                begin
                    push_en   = 1'b1;
                    push_byte = PAD_MARK;
                    mark_next = 1'b1;
                end
                else if (fill_reg == LEN_POS)
                begin
                    state_next = S_LEN;
                end
                else
                begin
                    push_en = 1'b1;
                end
            end
            S_LEN:
            begin
                // the length register empties itself as it is shifted out
                push_en      = 1'b1;
                push_byte    = bit_len_reg[63:56];
                bit_len_next = {bit_len_reg[55:0], 8'd0};
                len_cnt_next = len_cnt_reg + 4'd1;
                if (len_cnt_reg == 4'd7)
                    after_push = S_OUT;
            end
            S_ROUND:
            begin
                work_next[7] = work_reg[6];
                work_next[6] = work_reg[5];
                work_next[5] = work_reg[4];
                work_next[4] = work_reg[3] + t1;
                work_next[3] = work_reg[2];
                work_next[2] = work_reg[1];
                work_next[1] = work_reg[0];
                work_next[0] = t1 + t2;
                blk_next     = {blk_reg[479:0], sched_new};
                round_next   = round_reg + 6'd1;
                if (round_reg == 6'(ROUNDS - 1))
                    state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                for (int i = 0; i < NUM_HASH; i++)
                    chain_next[i] = chain_reg[i] + work_reg[i];
                state_next = resume_reg;
            end
            S_OUT:
            begin
                if (m_tready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'(NUM_HASH - 1))
                    begin
                        chain_next   = IV;
                        mark_next    = 1'b0;
                        len_cnt_next = '0;
                        state_next   = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // byte shifted into the block; a full block starts the rounds
        if (push_en)
        begin
            blk_next  = {blk_reg[BLOCK_W-9:0], push_byte};
            fill_next = fill_reg + 6'd1;
            if (fill_reg == FILL_TOP)
            begin
                state_next  = S_ROUND;
                resume_next = after_push;
                round_next  = '0;
                work_next   = chain_reg;
            end
            else
            begin
                state_next = after_push;
            end
        end
    end

    // control state and chaining value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            resume_reg  <= S_IDLE;
            fill_reg    <= '0;
            bit_len_reg <= '0;
            cnt_reg     <= '0;
            last_reg    <= 1'b0;
            mark_reg    <= 1'b0;
            len_cnt_reg <= '0;
            round_reg   <= '0;
            idx_reg     <= '0;
            chain_reg   <= IV;
        end
        else
        begin
            state_reg   <= state_next;
            resume_reg  <= resume_next;
            fill_reg    <= fill_next;
            bit_len_reg <= bit_len_next;
            cnt_reg     <= cnt_next;
            last_reg    <= last_next;
            mark_reg    <= mark_next;
            len_cnt_reg <= len_cnt_next;
            round_reg   <= round_next;
            idx_reg     <= idx_next;
            chain_reg   <= chain_next;
        end
    end

    // block, message word and working words
    always_ff @(posedge clk)
    begin
        blk_reg  <= blk_next;
        data_reg <= data_next;
        work_reg <= work_next;
    end

    // ports
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {5'd0, idx_reg, chain_reg[idx_reg]};
    assign m_tlast  = (idx_reg == 3'(NUM_HASH - 1));

    // checks
    `SHA_ASSERT(a_no_overlap, clk, rst_n, !(s_tready && m_tvalid))
    `SHA_ASSERT(a_round_idle, clk, rst_n, (state_reg == S_ROUND) || (round_reg == 6'd0))
    `SHA_ASSERT(a_round_entry, clk, rst_n,
        $rose(state_reg == S_ROUND) |-> ($past(fill_reg) == FILL_TOP))
    `SHA_ASSERT_NEXT(a_clean_finish, clk, rst_n, m_tvalid && m_tready && m_tlast,
        (fill_reg == 6'd0) && (bit_len_reg == 64'd0) && s_tready)

endmodule

[tb/tb_sha256_hash_engine.sv]
// self-checking testbench for the streaming sha-256 hash engine
`timescale 1ns / 1ps

module tb_sha256_hash_engine;

    import sha_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 10;
    localparam int STALL_LIMIT   = 3000;
    localparam int DRAIN_CYCLES  = 300;
    localparam int TARGET_CHUNKS = 160;
    localparam int CALM_CHUNKS   = 25;
    localparam int MAX_REPORTS   = 10;

    // fips 180-4 initial hash words and round constants
    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // message lengths around the padding boundaries
    localparam int EDGE_LENS [9] = '{0, 55, 56, 57, 63, 64, 65, 119, 120};

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam int         LENGTH_AT  = 56;
    localparam int         BLOCK_SIZE = 64;

    // one transfer of message bytes; hold_off waits for all digests first
    typedef struct {
        logic [31:0] data;
        logic [2:0]  cnt;
        logic        last;
        bit          hold_off;
    } msg_chunk_t;

    typedef struct {
        word_t      word;
        logic [2:0] idx;
        logic       fin;
    } digest_rec_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;

    msg_chunk_t  chunk_q [$];
    msg_chunk_t  cur_chunk;
    digest_rec_t digest_q [$];
    digest_rec_t want, got;

    // predictor state
    logic [31:0] hash_state [8];
    logic [7:0]  blk_bytes [64];
    int          blk_fill;
    logic [63:0] msg_bits;

    logic in_took = 1'b0;
    int   gap_left = 0;
    int   stall_left = 0;
    int   idle_cycles = 0;
    int   mismatches = 0;

    sha256_hash_engine dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #CLK_HALF clk = ~clk;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void restart_hash();
        for (int i = 0; i < 8; i++)
            hash_state[i] = INIT_HASH[i];
        blk_fill = 0;
        msg_bits = '0;
    endfunction

    // 64 rounds over the buffered block, folded into the hash state
    function automatic void run_rounds();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int r = 0; r < 16; r++)
            w[r] = {blk_bytes[4*r], blk_bytes[4*r+1], blk_bytes[4*r+2], blk_bytes[4*r+3]};
        for (int r = 16; r < 64; r++)
            w[r] = w[r-16] + w[r-7]
                 + (ror32(w[r-15], 7) ^ ror32(w[r-15], 18) ^ (w[r-15] >> 3))
                 + (ror32(w[r-2], 17) ^ ror32(w[r-2], 19) ^ (w[r-2] >> 10));
        a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
        e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
        for (int r = 0; r < 64; r++)
        begin
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25))
               + ((e & f) ^ (~e & g)) + ROUND_K[r] + w[r];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22))
               + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
        hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
    endfunction

    function automatic void absorb_byte(input logic [7:0] b);
        blk_bytes[blk_fill] = b;
        blk_fill++;
        if (blk_fill == BLOCK_SIZE)
        begin
            run_rounds();
            blk_fill = 0;
        end
    endfunction

    // absorb one accepted transfer; on last, pad and queue the eight digest words
    function automatic void hash_chunk(input msg_chunk_t ch);
        int          n;
        logic [63:0] total;
        digest_rec_t rec;
        n = (ch.cnt > 3'd4) ? 4 : int'(ch.cnt);
        for (int i = 0; i < n; i++)
            absorb_byte(ch.data[31 - 8*i -: 8]);
        msg_bits += 64'(n * 8);
        if (ch.last)
        begin
            total = msg_bits;
            absorb_byte(PAD_BYTE);
            while (blk_fill != LENGTH_AT)
                absorb_byte(8'h00);
            for (int i = 0; i < 8; i++)
                absorb_byte(total[63 - 8*i -: 8]);
            for (int i = 0; i < 8; i++)
            begin
                rec.word = hash_state[i];
                rec.idx  = 3'(i);
                rec.fin  = (i == 7);
                digest_q.push_back(rec);
            end
            restart_hash();
        end
    endfunction

    function automatic void add_chunk(input logic [31:0] data, input int cnt,
                                      input bit last, input bit hold_off);
        msg_chunk_t ch;
        ch.data     = data;
        ch.cnt      = 3'(cnt);
        ch.last     = last;
        ch.hold_off = hold_off;
        chunk_q.push_back(ch);
    endfunction

    // split a message of random bytes into transfers of mixed size
    function automatic void add_message(input int nbytes, input bit hold_off);
        int left, take, cnt;
        bit closed, first;
        left   = nbytes;
        closed = 1'b0;
        first  = hold_off;
        while (left > 0)
        begin
            take = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : 4;
            if (take > left)
                take = left;
            cnt = take;
            // saturating byte counts
            if (take == 4 && $urandom_range(0, 3) == 0)
                cnt = $urandom_range(5, 7);
            left -= take;
            closed = (left == 0) && ($urandom_range(0, 2) != 0);
            add_chunk($urandom, cnt, closed, first);
            first = 1'b0;
        end
        // message closed by an empty last transfer
        if (!closed)
            add_chunk($urandom, 0, 1'b1, first);
    endfunction

    function automatic void report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t %s: expected idx %0d word %h last %b, got idx %0d word %h last %b",
                     $realtime, what, want.idx, want.word, want.fin,
                     got.idx, got.word, got.fin);
    endfunction

    // input transfer sampled on the rising edge
    always @(posedge clk)
        in_took <= rst_n && s_tvalid && s_tready;

    // driver: predicts accepted transfers and presents the next one
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_took)
                hash_chunk(cur_chunk);
            if (s_tvalid && !in_took)
            begin
                // still waiting for the current transfer
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (chunk_q.size() == 0)
            begin
                s_tvalid <= 1'b0;
            end
            else if (chunk_q[0].hold_off && digest_q.size() != 0)
            begin
                s_tvalid <= 1'b0;
            end
            else if (chunk_q.size() > CALM_CHUNKS && $urandom_range(0, 6) == 0)
            begin
                gap_left = $urandom_range(0, 3);
                s_tvalid <= 1'b0;
            end
            else
            begin
                cur_chunk = chunk_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {5'b0, cur_chunk.cnt, cur_chunk.data};
                s_tlast  <= cur_chunk.last;
            end
        end
    end

    // receiver back-pressure in short bursts, none near the end
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (chunk_q.size() > CALM_CHUNKS && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 3);
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // monitor: each digest transfer against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got.word = m_tdata[31:0];
            got.idx  = m_tdata[34:32];
            got.fin  = m_tlast;
            if (digest_q.size() == 0)
            begin
                want = '{default: '0};
                report_mismatch("unexpected digest word");
            end
            else
            begin
                want = digest_q.pop_front();
                if (got.word !== want.word || got.idx !== want.idx || got.fin !== want.fin)
                    report_mismatch("digest mismatch");
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("timeout after %0d idle cycles", idle_cycles);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin
        restart_hash();
        // empty message
        add_chunk(32'hffffffff, 0, 1'b1, 1'b0);
        // three bytes in one last transfer, junk below them
        add_chunk(32'h616263a5, 3, 1'b1, 1'b1);
        // 56 bytes of extremes: length field spills into a second block
        for (int i = 0; i < 14; i++)
            add_chunk((i % 2) ? 32'hffffffff : 32'h00000000, 4 + (i % 4), i == 13, i == 0);
        // one, two and four bytes, then an empty last transfer
        add_chunk(32'ha5123456, 1, 1'b0, 1'b1);
        add_chunk(32'h5a7f0000, 2, 1'b0, 1'b0);
        add_chunk(32'h12345678, 4, 1'b0, 1'b0);
        add_chunk(32'hdeadbeef, 0, 1'b1, 1'b0);

        // random messages, some at padding boundaries
        while (chunk_q.size() < TARGET_CHUNKS)
        begin
            int nbytes;
            nbytes = ($urandom_range(0, 3) == 0) ? EDGE_LENS[$urandom_range(0, 8)]
                                                : $urandom_range(0, 40);
            add_message(nbytes, $urandom_range(0, 4) == 0);
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (chunk_q.size() != 0 || s_tvalid || in_took)
            @(posedge clk);
        while (digest_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
